### hdl/assert_macros.svh
// assertion macros used by the checker top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/eas_pkg.sv
// shared types and constants of the address syntax checker
package eas_pkg;

  localparam int CountBits = 10;
  localparam int LimitW    = 10;
  localparam int CmpW      = (CountBits > LimitW) ? CountBits : LimitW;
  localparam int CharW     = 8;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgTotal  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLocal  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDomain = 2'd2;

  localparam logic [LimitW-1:0] TotalLimitRst  = 10'd320;
  localparam logic [LimitW-1:0] LocalLimitRst  = 10'd64;
  localparam logic [LimitW-1:0] DomainLimitRst = 10'd255;

  localparam logic [CharW-1:0] ChAt   = 8'h40;
  localparam logic [CharW-1:0] ChDot  = 8'h2e;
  localparam logic [CharW-1:0] ChDash = 8'h2d;

  typedef enum logic [3:0] {
    VerdictOk          = 4'd0,
    VerdictTooLong     = 4'd1,
    VerdictSeveralAt   = 4'd2,
    VerdictNoAt        = 4'd3,
    VerdictLocalLen    = 4'd4,
    VerdictLocalEdge   = 4'd5,
    VerdictLocalChar   = 4'd6,
    VerdictLocalDouble = 4'd7,
    VerdictDomainLen   = 4'd8,
    VerdictEmptyLabel  = 4'd9,
    VerdictLabelDash   = 4'd10,
    VerdictDomainChar  = 4'd11
  } verdict_e;

  typedef struct packed {
    logic is_at;
    logic is_dot;
    logic is_dash;
    logic is_alnum;
  } char_class_t;

endpackage

### hdl/eas_char_class.sv
// byte classifier: at sign, dot, dash, ascii letter or digit
module eas_char_class (
  input  logic [eas_pkg::CharW-1:0] char_code_i,
  output eas_pkg::char_class_t      class_o
);

  logic lower, upper, digit;

  assign lower = (char_code_i >= 8'h61) && (char_code_i <= 8'h7a);
  assign upper = (char_code_i >= 8'h41) && (char_code_i <= 8'h5a);
  assign digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);

  assign class_o.is_at    = (char_code_i == eas_pkg::ChAt);
  assign class_o.is_dot   = (char_code_i == eas_pkg::ChDot);
  assign class_o.is_dash  = (char_code_i == eas_pkg::ChDash);
  assign class_o.is_alnum = lower | upper | digit;

endmodule

### hdl/eas_scan.sv
// address scan state: counters, latched faults and the verdict of the last byte
module eas_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       is_last_i,
  input  eas_pkg::char_class_t       class_i,
  input  logic [eas_pkg::LimitW-1:0] total_limit_i,
  input  logic [eas_pkg::LimitW-1:0] local_limit_i,
  input  logic [eas_pkg::LimitW-1:0] domain_limit_i,
  output eas_pkg::verdict_e          verdict_o
);

  typedef enum logic [1:0] {
    LocErrNone   = 2'd0,
    LocErrChar   = 2'd1,
    LocErrDouble = 2'd2
  } loc_err_e;

  typedef enum logic [1:0] {
    DomErrNone  = 2'd0,
    DomErrEmpty = 2'd1,
    DomErrDash  = 2'd2,
    DomErrChar  = 2'd3
  } dom_err_e;

  typedef logic [eas_pkg::CountBits-1:0] count_t;

  typedef struct packed {
    count_t cnt;
    logic   first_dash;
    logic   last_dash;
    logic   bad_char;
  } label_t;

  typedef struct packed {
    count_t   total;
    logic [1:0] at;
    count_t   loc;
    count_t   dom;
    logic     loc_first_punct;
    logic     prev_punct;
    loc_err_e loc_err;
    label_t   label;
    dom_err_e dom_err;
  } scan_t;

  localparam count_t CntMax = '1;

  function automatic count_t sat_inc(count_t v);
    sat_inc = (v == CntMax) ? v : v + count_t'(1);
  endfunction

  function automatic dom_err_e label_err(label_t l);
    if (l.cnt == '0) begin
      label_err = DomErrEmpty;
    end else if (l.first_dash || l.last_dash) begin
      label_err = DomErrDash;
    end else if (l.bad_char) begin
      label_err = DomErrChar;
    end else begin
      label_err = DomErrNone;
    end
  endfunction

  scan_t    st_q, st_d, st_n;
  dom_err_e dom_err_f;
  logic     punct;
  logic     last_at_one;

  assign punct = class_i.is_dot | class_i.is_dash;

  always_comb begin
    st_n       = st_q;
    st_n.total = sat_inc(st_q.total);
    if (class_i.is_at) begin
      if (st_q.at != 2'd2) begin
        st_n.at = st_q.at + 2'd1;
      end
    end else if (st_q.at == 2'd0) begin
      if (st_q.loc == '0) begin
        st_n.loc_first_punct = punct;
      end
      if (st_q.loc_err == LocErrNone) begin
        if (!(class_i.is_alnum || punct)) begin
          st_n.loc_err = LocErrChar;
        end else if (punct && st_q.prev_punct) begin
          st_n.loc_err = LocErrDouble;
        end
      end
      st_n.prev_punct = punct;
      st_n.loc        = sat_inc(st_q.loc);
    end else if (st_q.at == 2'd1) begin
      st_n.dom = sat_inc(st_q.dom);
      if (class_i.is_dot) begin
        if (st_q.dom_err == DomErrNone) begin
          st_n.dom_err = label_err(st_q.label);
        end
        st_n.label = '0;
      end else begin
        if (st_q.label.cnt == '0) begin
          st_n.label.first_dash = class_i.is_dash;
        end
        st_n.label.last_dash = class_i.is_dash;
        if (!(class_i.is_alnum || class_i.is_dash)) begin
          st_n.label.bad_char = 1'b1;
        end
        st_n.label.cnt = sat_inc(st_q.label.cnt);
      end
    end
  end

  // the final label closes at the end of the address
  assign last_at_one = (st_n.at == 2'd1);
  assign dom_err_f   = (last_at_one && st_n.dom_err == DomErrNone) ?
                       label_err(st_n.label) : st_n.dom_err;

  always_comb begin
    priority if (eas_pkg::CmpW'(st_n.total) > eas_pkg::CmpW'(total_limit_i)) begin
      verdict_o = eas_pkg::VerdictTooLong;
    end else if (st_n.at == 2'd2) begin
      verdict_o = eas_pkg::VerdictSeveralAt;
    end else if (st_n.at == 2'd0) begin
      verdict_o = eas_pkg::VerdictNoAt;
    end else if (st_n.loc == '0 ||
                 eas_pkg::CmpW'(st_n.loc) > eas_pkg::CmpW'(local_limit_i)) begin
      verdict_o = eas_pkg::VerdictLocalLen;
    end else if (st_n.loc_first_punct || st_n.prev_punct) begin
      verdict_o = eas_pkg::VerdictLocalEdge;
    end else if (st_n.loc_err == LocErrChar) begin
      verdict_o = eas_pkg::VerdictLocalChar;
    end else if (st_n.loc_err == LocErrDouble) begin
      verdict_o = eas_pkg::VerdictLocalDouble;
    end else if (st_n.dom == '0 ||
                 eas_pkg::CmpW'(st_n.dom) > eas_pkg::CmpW'(domain_limit_i)) begin
      verdict_o = eas_pkg::VerdictDomainLen;
    end else if (dom_err_f == DomErrEmpty) begin
      verdict_o = eas_pkg::VerdictEmptyLabel;
    end else if (dom_err_f == DomErrDash) begin
      verdict_o = eas_pkg::VerdictLabelDash;
    end else if (dom_err_f == DomErrChar) begin
      verdict_o = eas_pkg::VerdictDomainChar;
    end else begin
      verdict_o = eas_pkg::VerdictOk;
    end
  end

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = is_last_i ? scan_t'('0) : st_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### hdl/email_address_syntax_check_top.sv
// Streaming address syntax checker: one byte per cycle in, one verdict per address out.
// Each accepted byte waits in an input register, then one pass of classify and state update
// decides the next scan state and, on the byte marked last, the verdict, which is held in an
// output register until taken. The block sustains one byte per cycle unless a last byte
// waits on a full output register. A verdict is registered as its last byte leaves the
// input register. The rate is set by the scan state update. The user must write the limits
// through the configuration port while no address is in flight; the block does not check it.
`include "assert_macros.svh"

module email_address_syntax_check_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [eas_pkg::CharW-1:0]   char_code_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  verdict_o,
  input  logic                        cfg_we_i,
  input  logic [eas_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [eas_pkg::LimitW-1:0]  cfg_data_i
);

  logic [eas_pkg::LimitW-1:0] total_limit_q, local_limit_q, domain_limit_q;

  logic                      s1_valid_q, s1_valid_d;
  logic [eas_pkg::CharW-1:0] s1_char_q;
  logic                      s1_last_q;
  logic                      s1_fire, out_free, in_fire;

  logic              out_valid_q, out_valid_d;
  eas_pkg::verdict_e verdict_q, verdict_c;

  eas_pkg::char_class_t cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_limit_q  <= eas_pkg::TotalLimitRst;
      local_limit_q  <= eas_pkg::LocalLimitRst;
      domain_limit_q <= eas_pkg::DomainLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eas_pkg::CfgTotal:  total_limit_q  <= cfg_data_i;
        eas_pkg::CfgLocal:  local_limit_q  <= cfg_data_i;
        eas_pkg::CfgDomain: domain_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a byte without a verdict never waits on the output side
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = (s1_fire && s1_last_q) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_code_i;
      s1_last_q <= is_last_i;
    end
    if (s1_fire && s1_last_q) begin
      verdict_q <= verdict_c;
    end
  end

  eas_char_class u_class (
    .char_code_i (s1_char_q),
    .class_o     (cls)
  );

  eas_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_fire),
    .is_last_i      (s1_last_q),
    .class_i        (cls),
    .total_limit_i  (total_limit_q),
    .local_limit_i  (local_limit_q),
    .domain_limit_i (domain_limit_q),
    .verdict_o      (verdict_c)
  );

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  `ASSERT_NEXT(a_last_gives_verdict, clk_i, rst_ni, s1_fire && s1_last_q, out_valid_q)
  `ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q))
  `ASSERT_IMPLY(a_empty_stage_ready, clk_i, rst_ni, !s1_valid_q, in_ready_o)
  `ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !(s1_fire && s1_last_q))

endmodule

### tb/tb.sv
// testbench for the streaming address syntax checker, with a built-in verdict predictor
module tb;

  localparam int CW          = eas_pkg::CountBits;
  localparam int ItemTarget  = 1450;
  localparam int QuietLimit  = 2000;
  localparam int MaxReported = 10;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [eas_pkg::CharW-1:0] byte_q_t[$];

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [eas_pkg::CharW-1:0]   char_code_i;
  logic                        is_last_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [3:0]                  verdict_o;
  logic                        cfg_we_i;
  logic [eas_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [eas_pkg::LimitW-1:0]  cfg_data_i;

  email_address_syntax_check_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the limits and scan state
  logic [eas_pkg::LimitW-1:0] lim_total, lim_local, lim_domain;
  cnt_t              n_total, n_local, n_domain, n_label;
  logic [1:0]        n_at;
  bit                loc_lead_punct, loc_prev_punct;
  bit                lbl_lead_dash, lbl_trail_dash, lbl_bad;
  eas_pkg::verdict_e loc_fault, dom_fault;

  eas_pkg::verdict_e verdict_q[$];
  int       fault_count;
  int       items_sent;
  int       quiet_cycles;
  int       stall_left;
  bit       idle_on;

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic bit is_alnum(logic [eas_pkg::CharW-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic void finish_label();
    eas_pkg::verdict_e e;
    e = eas_pkg::VerdictOk;
    if (n_label == '0) e = eas_pkg::VerdictEmptyLabel;
    else if (lbl_lead_dash || lbl_trail_dash) e = eas_pkg::VerdictLabelDash;
    else if (lbl_bad) e = eas_pkg::VerdictDomainChar;
    if (dom_fault == eas_pkg::VerdictOk) dom_fault = e;
    n_label = '0;
    lbl_lead_dash = 1'b0;
    lbl_trail_dash = 1'b0;
    lbl_bad = 1'b0;
  endfunction

  function automatic void clear_scan();
    n_total = '0;
    n_local = '0;
    n_domain = '0;
    n_at = '0;
    loc_lead_punct = 1'b0;
    loc_prev_punct = 1'b0;
    loc_fault = eas_pkg::VerdictOk;
    dom_fault = eas_pkg::VerdictOk;
    n_label = '0;
    lbl_lead_dash = 1'b0;
    lbl_trail_dash = 1'b0;
    lbl_bad = 1'b0;
  endfunction

  // one byte of the address; gives a verdict on the last byte
  function automatic void scan_byte(input logic [eas_pkg::CharW-1:0] c, input bit last,
                                    output bit has, output eas_pkg::verdict_e v);
    bit punct;
    punct = (c == eas_pkg::ChDot) || (c == eas_pkg::ChDash);
    has = 1'b0;
    v = eas_pkg::VerdictOk;
    n_total = sat_inc(n_total);
    if (c == eas_pkg::ChAt) begin
      if (n_at < 2) n_at = n_at + 1'b1;
    end else if (n_at == 0) begin
      if (n_local == '0) loc_lead_punct = punct;
      if (loc_fault == eas_pkg::VerdictOk) begin
        if (!(is_alnum(c) || punct)) loc_fault = eas_pkg::VerdictLocalChar;
        else if (punct && loc_prev_punct) loc_fault = eas_pkg::VerdictLocalDouble;
      end
      loc_prev_punct = punct;
      n_local = sat_inc(n_local);
    end else if (n_at == 1) begin
      // bytes after a second at sign are not tracked
      n_domain = sat_inc(n_domain);
      if (c == eas_pkg::ChDot) begin
        finish_label();
      end else begin
        if (n_label == '0) lbl_lead_dash = (c == eas_pkg::ChDash);
        lbl_trail_dash = (c == eas_pkg::ChDash);
        if (!(is_alnum(c) || c == eas_pkg::ChDash)) lbl_bad = 1'b1;
        n_label = sat_inc(n_label);
      end
    end
    if (last) begin
      has = 1'b1;
      if (n_at == 1) finish_label();
      if (n_total > lim_total) v = eas_pkg::VerdictTooLong;
      else if (n_at >= 2) v = eas_pkg::VerdictSeveralAt;
      else if (n_at == 0) v = eas_pkg::VerdictNoAt;
      else if (n_local == '0 || n_local > lim_local) v = eas_pkg::VerdictLocalLen;
      else if (loc_lead_punct || loc_prev_punct) v = eas_pkg::VerdictLocalEdge;
      else if (loc_fault != eas_pkg::VerdictOk) v = loc_fault;
      else if (n_domain == '0 || n_domain > lim_domain) v = eas_pkg::VerdictDomainLen;
      else v = dom_fault;
      clear_scan();
    end
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= MaxReported) $display("%s", msg);
  endfunction

  // monitors and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    bit                has;
    eas_pkg::verdict_e v;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        scan_byte(char_code_i, is_last_i, has, v);
        if (has) verdict_q.push_back(v);
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          note_fault($sformatf("unexpected verdict %0d with none pending", verdict_o));
        end else begin
          v = verdict_q.pop_front();
          if (verdict_o !== v)
            note_fault($sformatf("verdict mismatch: expected %0d (%s), got %0d",
                                 v, v.name(), verdict_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // verdict side stalls in random bursts while idle_on is set
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_byte(input logic [eas_pkg::CharW-1:0] c, input bit last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    is_last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_addr(input byte_q_t a);
    foreach (a[i]) send_byte(a[i], i == a.size() - 1);
  endtask

  // drop valid and wait until every verdict has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_limits(input logic [eas_pkg::LimitW-1:0] t,
                              input logic [eas_pkg::LimitW-1:0] l,
                              input logic [eas_pkg::LimitW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= eas_pkg::CfgTotal;
    cfg_data_i <= t;
    @(negedge clk_i);
    cfg_idx_i <= eas_pkg::CfgLocal;
    cfg_data_i <= l;
    @(negedge clk_i);
    cfg_idx_i <= eas_pkg::CfgDomain;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lim_total = t;
    lim_local = l;
    lim_domain = d;
  endtask

  function automatic byte_q_t text(string s);
    byte_q_t a;
    for (int i = 0; i < s.len(); i++) a.push_back(s[i]);
    return a;
  endfunction

  function automatic logic [eas_pkg::CharW-1:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return eas_pkg::CharW'("a" + $urandom_range(0, 25));
      1: return eas_pkg::CharW'("A" + $urandom_range(0, 25));
      default: return eas_pkg::CharW'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [eas_pkg::LimitW-1:0] rand_limit();
    case ($urandom_range(0, 8))
      0: return '0;
      1: return '1;
      2: return eas_pkg::LimitW'($urandom_range(1, 12));
      3: return eas_pkg::LimitW'($urandom_range(1, 40));
      4: return eas_pkg::LimitW'($urandom_range(0, 1023));
      default: return eas_pkg::LimitW'($urandom_range(40, 1023));
    endcase
  endfunction

  // mostly well-formed addresses with random content, some damaged, some pure noise
  function automatic byte_q_t make_addr();
    byte_q_t a;
    int      n;
    int      labels;
    int      len;
    int      pos;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) a.push_back(eas_pkg::CharW'($urandom_range(0, 255)));
      return a;
    end
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i < n - 1 && $urandom_range(0, 4) == 0 &&
          a[$] != eas_pkg::ChDot && a[$] != eas_pkg::ChDash)
        a.push_back($urandom_range(0, 1) ? eas_pkg::ChDot : eas_pkg::ChDash);
      else
        a.push_back(rand_alnum());
    end
    a.push_back(eas_pkg::ChAt);
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 7);
      for (int j = 0; j < len; j++) begin
        if (j > 0 && j < len - 1 && $urandom_range(0, 4) == 0) a.push_back(eas_pkg::ChDash);
        else a.push_back(rand_alnum());
      end
      if (l < labels - 1) a.push_back(eas_pkg::ChDot);
    end
    if ($urandom_range(0, 2) == 0) begin
      pos = $urandom_range(0, a.size() - 1);
      case ($urandom_range(0, 5))
        0: a[pos] = eas_pkg::CharW'($urandom_range(0, 255));
        1: a[pos] = $urandom_range(0, 1) ? eas_pkg::ChDot : eas_pkg::ChDash;
        2: a.insert(pos, eas_pkg::ChAt);
        3: if (a.size() > 1) a.delete(pos);
        4: a.insert(pos, $urandom_range(0, 1) ? eas_pkg::ChDot : eas_pkg::ChDash);
        default: a[pos] = eas_pkg::CharW'($urandom_range(128, 255));
      endcase
    end
    return a;
  endfunction

  // at least one address for each verdict code except too long, under the reset limits
  task automatic test_directed_verdicts();
    byte_q_t a;
    send_addr(text("Z9@x0.Y-z"));
    send_addr(text("a"));
    send_addr(text("@"));
    send_addr(text("a@@"));
    send_addr(text(".@b"));
    send_addr(text("!@b"));
    send_addr(text("a.-a@b"));
    send_addr(text("a@"));
    send_addr(text("a@."));
    send_addr(text("a@-"));
    a = text("a@");
    a.push_back(8'hff);
    send_addr(a);
    a = text("a@");
    a.push_back(8'h00);
    send_addr(a);
    settle();
  endtask

  // zero, tight and full-scale limits
  task automatic test_limit_extremes();
    write_limits('0, '0, '0);
    send_addr(text("a@b"));
    settle();
    write_limits('1, '0, '1);
    send_addr(text("a@b"));
    settle();
    write_limits('1, '1, '0);
    send_addr(text("a@b"));
    settle();
    write_limits(10'd4, 10'd1, 10'd2);
    send_addr(text("a@bc"));
    send_addr(text("ab@c"));
    send_addr(text("a@bcd"));
    settle();
  endtask

  // an address long enough to pin the total and local counters at full scale
  task automatic test_counter_saturation();
    byte_q_t a;
    write_limits('1, '1, '1);
    repeat (1030) a.push_back(rand_alnum());
    a.push_back(eas_pkg::ChAt);
    a.push_back("a");
    a.push_back(eas_pkg::ChDot);
    a.push_back("b");
    send_addr(a);
    settle();
  endtask

  task automatic test_random_addresses();
    int target;
    int n_addr;
    target = ItemTarget;
    while (items_sent < target) begin
      idle_on = (items_sent < target - 150) && ($urandom_range(0, 3) != 0);
      write_limits(rand_limit(), rand_limit(), rand_limit());
      n_addr = $urandom_range(10, 30);
      for (int k = 0; k < n_addr && items_sent < target; k++) begin
        if (items_sent >= target - 150) idle_on = 1'b0;
        send_addr(make_addr());
      end
      settle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    is_last_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = eas_pkg::CfgTotal;
    cfg_data_i = '0;
    stall_left = 0;
    idle_on = 1'b1;
    fault_count = 0;
    items_sent = 0;
    quiet_cycles = 0;
    lim_total = eas_pkg::TotalLimitRst;
    lim_local = eas_pkg::LocalLimitRst;
    lim_domain = eas_pkg::DomainLimitRst;
    clear_scan();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_verdicts();
    test_limit_extremes();
    test_counter_saturation();
    test_random_addresses();

    if (fault_count == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/eas_pkg.sv
hdl/eas_char_class.sv
hdl/eas_scan.sv
hdl/email_address_syntax_check_top.sv
tb/tb.sv
